>>> src/rcm_pkg.sv
package rcm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MARK_W   = 2;
	localparam int REG_W    = 32;
	localparam int ADDR_W   = 3;

	localparam logic [MARK_W-1:0] MARK_NORMAL  = 2'd0;
	localparam logic [MARK_W-1:0] MARK_MISSING = 2'd1;
	localparam logic [MARK_W-1:0] MARK_NAN     = 2'd2;

	localparam logic [ADDR_W-1:0] REG_LOWER_EDGE      = 3'd0;
	localparam logic [ADDR_W-1:0] REG_CENTER_POINT    = 3'd1;
	localparam logic [ADDR_W-1:0] REG_UPPER_EDGE      = 3'd2;
	localparam logic [ADDR_W-1:0] REG_LOWER_UNBOUNDED = 3'd3;
	localparam logic [ADDR_W-1:0] REG_UPPER_UNBOUNDED = 3'd4;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_ONE,
		KIND_LOOKUP
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [MARK_W-1:0] mark;
	} ctrl_t;

endpackage

>>> src/rcm_front.sv
module rcm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   take,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0]    sample,
	input  logic        [rcm_pkg::MARK_W-1:0]      sample_mark,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0]    lower_edge,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0]    center_point,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0]    upper_edge,
	input  logic                                   lower_unbounded,
	input  logic                                   upper_unbounded,
	output rcm_pkg::ctrl_t                         ctrl_s1,
	output logic        [rcm_pkg::SAMPLE_W-1:0]    dist_s1,
	output logic        [rcm_pkg::SAMPLE_W-1:0]    span_s1
);
	import rcm_pkg::*;

	logic [SAMPLE_W:0]   dist_lo;
	logic [SAMPLE_W:0]   span_lo;
	logic [SAMPLE_W:0]   dist_hi;
	logic [SAMPLE_W:0]   span_hi;
	kind_t               kind_d;
	logic [MARK_W-1:0]   mark_d;
	logic [SAMPLE_W-1:0] dist_d;
	logic [SAMPLE_W-1:0] span_d;

	assign dist_lo = {center_point[SAMPLE_W-1], center_point} - {sample[SAMPLE_W-1], sample};
	assign span_lo = {center_point[SAMPLE_W-1], center_point}
		- {lower_edge[SAMPLE_W-1], lower_edge};
	assign dist_hi = {sample[SAMPLE_W-1], sample} - {center_point[SAMPLE_W-1], center_point};
	assign span_hi = {upper_edge[SAMPLE_W-1], upper_edge}
		- {center_point[SAMPLE_W-1], center_point};

	always_comb begin
		kind_d = KIND_ZERO;
		mark_d = MARK_NORMAL;
		dist_d = '0;
		span_d = SAMPLE_W'(1);
		if (sample_mark != MARK_NORMAL) begin
			mark_d = (sample_mark == MARK_MISSING) ? MARK_MISSING : MARK_NAN;
		end else if ((!lower_unbounded && sample < lower_edge)
				|| (!upper_unbounded && sample > upper_edge)) begin
			kind_d = KIND_ZERO;
		end else if (sample < center_point) begin
			if (lower_unbounded) begin
				kind_d = KIND_ONE;
			end else if (lower_edge >= center_point) begin
				kind_d = KIND_ZERO;
			end else begin
				kind_d = KIND_LOOKUP;
				dist_d = dist_lo[SAMPLE_W-1:0];
				span_d = span_lo[SAMPLE_W-1:0];
			end
		end else if (sample == center_point) begin
			kind_d = KIND_ONE;
		end else begin
			if (upper_unbounded) begin
				kind_d = KIND_ONE;
			end else if (upper_edge <= center_point) begin
				kind_d = KIND_ZERO;
			end else begin
				kind_d = KIND_LOOKUP;
				dist_d = dist_hi[SAMPLE_W-1:0];
				span_d = span_hi[SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1.valid <= 1'b0;
		end else begin
			ctrl_s1.valid <= take;
			ctrl_s1.kind  <= kind_d;
			ctrl_s1.mark  <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		dist_s1 <= dist_d;
		span_s1 <= span_d;
	end

endmodule

>>> src/rcm_div_cell.sv
module rcm_div_cell #(
	parameter int QW = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rcm_pkg::ctrl_t                   ctrl_i,
	input  logic [rcm_pkg::SAMPLE_W-1:0]     rem_i,
	input  logic [QW-1:0]                    low_i,
	input  logic [QW-1:0]                    quot_i,
	input  logic [rcm_pkg::SAMPLE_W-1:0]     span_i,
	output rcm_pkg::ctrl_t                   ctrl_s1,
	output logic [rcm_pkg::SAMPLE_W-1:0]     rem_s1,
	output logic [QW-1:0]                    low_s1,
	output logic [QW-1:0]                    quot_s1,
	output logic [rcm_pkg::SAMPLE_W-1:0]     span_s1
);
	import rcm_pkg::*;

	logic [SAMPLE_W:0] trial;
	logic [SAMPLE_W:0] diff;
	logic              fits;

	// one quotient bit per cell, remainder kept below span
	assign trial = {rem_i, low_i[QW-1]};
	assign diff  = trial - {1'b0, span_i};
	assign fits  = trial >= {1'b0, span_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1.valid <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1  <= fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
		low_s1  <= {low_i[QW-2:0], 1'b0};
		quot_s1 <= {quot_i[QW-2:0], fits};
		span_s1 <= span_i;
	end

endmodule

>>> src/rcm_lut.sv
module rcm_lut #(
	parameter int TABLE_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcm_pkg::ctrl_t          ctrl_i,
	input  logic [TABLE_BITS:0]     index_i,
	output rcm_pkg::ctrl_t          ctrl_s1,
	output logic [FRAC_BITS:0]      membership
);
	import rcm_pkg::*;

	localparam int N  = 1 << TABLE_BITS;
	localparam int QW = TABLE_BITS + 1;

	typedef logic [FRAC_BITS:0] rom_t [0:N];

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// shift and subtract quotient for the small series divisors
	function automatic logic [63:0] div_small(input logic [63:0] num, input logic [10:0] den);
		logic [63:0] q;
		logic [11:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[10:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// (1 + cos(pi*k/N)) / 2 as cos^2 of half the angle, series in Q4.60
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] frac_lo;
		logic [63:0] coarse;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum_v;
		logic [63:0] c2;
		logic [10:0] den;
		logic [63:0] rnd;
		frac_lo = HALF_PI_Q60 & 64'(N - 1);
		coarse  = HALF_PI_Q60 >> TABLE_BITS;
		for (int k = 0; k <= N; k++) begin
			theta = coarse * 64'(k) + ((frac_lo * 64'(k)) >> TABLE_BITS);
			x2    = mul_q60(theta, theta);
			term  = 64'd1 << 60;
			sum_v = 64'd1 << 60;
			for (int j = 1; j <= 20; j++) begin
				den  = 11'((2 * j - 1) * (2 * j));
				term = div_small(mul_q60(term, x2), den);
				if ((j % 2) == 1) begin
					sum_v = sum_v - term;
				end else begin
					sum_v = sum_v + term;
				end
			end
			if (sum_v > (64'd1 << 60)) begin
				sum_v = 64'd1 << 60;
			end
			c2   = mul_q60(sum_v, sum_v);
			rnd  = (c2 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
			r[k] = rnd[FRAC_BITS:0];
		end
		r[0] = {1'b1, {FRAC_BITS{1'b0}}};
		r[N] = '0;
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [QW-1:0]      index_c;
	logic [FRAC_BITS:0] rom_s1;

	assign index_c = (index_i > QW'(N)) ? QW'(N) : index_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1.valid <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		rom_s1 <= ROM[index_c];
	end

	always_comb begin
		case (ctrl_s1.kind)
			KIND_LOOKUP: membership = rom_s1;
			KIND_ONE:    membership = {1'b1, {FRAC_BITS{1'b0}}};
			default:     membership = '0;
		endcase
	end

endmodule

>>> src/rcm_fifo.sv
module rcm_fifo #(
	parameter int PTR_W = 4,
	parameter int DW    = 17
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_take,
	output logic                           full,
	input  logic                           wr_en,
	input  logic [DW-1:0]                  wr_memb,
	input  logic [rcm_pkg::MARK_W-1:0]     wr_mark,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [DW-1:0]                  membership,
	output logic [rcm_pkg::MARK_W-1:0]     result_mark
);
	import rcm_pkg::*;

	localparam int DEPTH = 1 << PTR_W;

	logic [DW-1:0]     memb_mem [DEPTH];
	logic [MARK_W-1:0] mark_mem [DEPTH];
	logic [PTR_W:0]    wr_ptr_q;
	logic [PTR_W:0]    rd_ptr_q;
	logic [PTR_W:0]    credit_q;
	logic              out_take;

	// credits count items in the pipe plus items held here
	assign full      = (credit_q == (PTR_W + 1)'(DEPTH));
	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign out_take  = out_valid && !out_stall;

	assign membership  = memb_mem[rd_ptr_q[PTR_W-1:0]];
	assign result_mark = mark_mem[rd_ptr_q[PTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			memb_mem[wr_ptr_q[PTR_W-1:0]] <= wr_memb;
			mark_mem[wr_ptr_q[PTR_W-1:0]] <= wr_mark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			credit_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (in_take && !out_take) begin
				credit_q <= credit_q + 1'b1;
			end else if (!in_take && out_take) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

endmodule

>>> src/raised_cosine_membership.sv
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   sample, sample_mark
// out      from block out_valid / out_stall membership, result_mark
// cfg      to block   cfg_wr                cfg_addr, cfg_data
//
// one item per cycle while in_stall is low; items pass the front, a divider
// chain of TABLE_BITS + 1 cells, the rom and the output store
// reset empties the pipe and output store and loads the default curve
// in_stall rises when items in flight fill the output store
// (2**clog2(TABLE_BITS + 5) entries); the pipe itself never stops
module raised_cosine_membership #(
	parameter int TABLE_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample,
	input  logic        [rcm_pkg::MARK_W-1:0]   sample_mark,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [FRAC_BITS:0]           membership,
	output logic        [rcm_pkg::MARK_W-1:0]   result_mark,
	input  logic                                cfg_wr,
	input  logic        [rcm_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic        [rcm_pkg::REG_W-1:0]    cfg_data
);
	import rcm_pkg::*;

	localparam int QW    = TABLE_BITS + 1;
	localparam int NUM_W = SAMPLE_W + QW;
	localparam int PTR_W = $clog2(TABLE_BITS + 5);

	logic signed [SAMPLE_W-1:0] lower_edge_q;
	logic signed [SAMPLE_W-1:0] center_point_q;
	logic signed [SAMPLE_W-1:0] upper_edge_q;
	logic                       lower_unbounded_q;
	logic                       upper_unbounded_q;

	logic                in_take;
	ctrl_t               front_ctrl;
	logic [SAMPLE_W-1:0] front_dist;
	logic [SAMPLE_W-1:0] front_span;
	logic [NUM_W-1:0]    num;

	ctrl_t               ctrl_c [QW+1];
	logic [SAMPLE_W-1:0] rem_c  [QW+1];
	logic [QW-1:0]       low_c  [QW+1];
	logic [QW-1:0]       quot_c [QW+1];
	logic [SAMPLE_W-1:0] span_c [QW+1];

	ctrl_t              lut_ctrl;
	logic [FRAC_BITS:0] lut_memb;

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_edge_q      <= -32'sd65536;
			center_point_q    <= 32'sd0;
			upper_edge_q      <= 32'sd65536;
			lower_unbounded_q <= 1'b0;
			upper_unbounded_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_LOWER_EDGE:      lower_edge_q      <= cfg_data;
				REG_CENTER_POINT:    center_point_q    <= cfg_data;
				REG_UPPER_EDGE:      upper_edge_q      <= cfg_data;
				REG_LOWER_UNBOUNDED: lower_unbounded_q <= cfg_data[0];
				REG_UPPER_UNBOUNDED: upper_unbounded_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rcm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (in_take),
		.sample          (sample),
		.sample_mark     (sample_mark),
		.lower_edge      (lower_edge_q),
		.center_point    (center_point_q),
		.upper_edge      (upper_edge_q),
		.lower_unbounded (lower_unbounded_q),
		.upper_unbounded (upper_unbounded_q),
		.ctrl_s1         (front_ctrl),
		.dist_s1         (front_dist),
		.span_s1         (front_span)
	);

	// dividend d * N + span / 2, quotient fits in QW bits since d <= span
	assign num = {1'b0, front_dist, {TABLE_BITS{1'b0}}}
		+ NUM_W'(front_span[SAMPLE_W-1:1]);

	assign ctrl_c[0] = front_ctrl;
	assign rem_c[0]  = num[NUM_W-1:QW];
	assign low_c[0]  = num[QW-1:0];
	assign quot_c[0] = '0;
	assign span_c[0] = front_span;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rcm_div_cell #(
			.QW (QW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_i  (ctrl_c[i]),
			.rem_i   (rem_c[i]),
			.low_i   (low_c[i]),
			.quot_i  (quot_c[i]),
			.span_i  (span_c[i]),
			.ctrl_s1 (ctrl_c[i+1]),
			.rem_s1  (rem_c[i+1]),
			.low_s1  (low_c[i+1]),
			.quot_s1 (quot_c[i+1]),
			.span_s1 (span_c[i+1])
		);
	end

	rcm_lut #(
		.TABLE_BITS (TABLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_lut (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_i     (ctrl_c[QW]),
		.index_i    (quot_c[QW]),
		.ctrl_s1    (lut_ctrl),
		.membership (lut_memb)
	);

	rcm_fifo #(
		.PTR_W (PTR_W),
		.DW    (FRAC_BITS + 1)
	) u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.full        (in_stall),
		.wr_en       (lut_ctrl.valid),
		.wr_memb     (lut_memb),
		.wr_mark     (lut_ctrl.mark),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.membership  (membership),
		.result_mark (result_mark)
	);

endmodule

>>> src/rcm_checker.sv
module rcm_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [FRAC_BITS:0]                membership,
	input logic [rcm_pkg::MARK_W-1:0]        result_mark
);
	import rcm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out item dropped while stalled");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_mark != MARK_NORMAL |-> membership == '0)
		else $error("marked item with nonzero membership");

	a_mark_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_mark == MARK_NORMAL || result_mark == MARK_MISSING
			|| result_mark == MARK_NAN))
		else $error("result mark out of range");

	a_memb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> membership <= {1'b1, {FRAC_BITS{1'b0}}})
		else $error("membership above one");

endmodule

bind raised_cosine_membership rcm_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_rcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.membership  (membership),
	.result_mark (result_mark)
);
